// ===== rtl/c65x_pkg.sv =====
// ----------------------------------------------------------------------------
// c65x_pkg
// Shared constants for the 6502 execute unit: flag positions, stack geometry
// and opcode groups.
// ----------------------------------------------------------------------------
package c65x_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int SAW         = $clog2(STACK_DEPTH);

    localparam int FC = 0;
    localparam int FZ = 1;
    localparam int FI = 2;
    localparam int FD = 3;
    localparam int FB = 4;
    localparam int FU = 5;
    localparam int FV = 6;
    localparam int FN = 7;

    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] P_RESET  = 8'h24;

    // Opcodes that touch the stack.
    localparam logic [7:0] OP_BRK = 8'h00;
    localparam logic [7:0] OP_JSR = 8'h20;
    localparam logic [7:0] OP_RTS = 8'h60;
    localparam logic [7:0] OP_RTI = 8'h40;
    localparam logic [7:0] OP_PHA = 8'h48;
    localparam logic [7:0] OP_PHP = 8'h08;
    localparam logic [7:0] OP_PLA = 8'h68;
    localparam logic [7:0] OP_PLP = 8'h28;

    // Number of stack pushes and pulls an opcode performs.
    function automatic logic [1:0] push_count(input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        case (op)
            OP_BRK:         n = 2'd3;
            OP_JSR:         n = 2'd2;
            OP_PHA, OP_PHP: n = 2'd1;
            default:        n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] pull_count(input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        case (op)
            OP_RTI:         n = 2'd3;
            OP_RTS:         n = 2'd2;
            OP_PLA, OP_PLP: n = 2'd1;
            default:        n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/cpu6502_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// cpu6502_execute_unit_core
// Executes one pre-fetched 6502 instruction per request against A, X, Y, S, P
// and a private page-one stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  | signals                                      | role
//  ---------+----------------------------------------------+-----------------
//  in       | in_valid, in_stall, cmd, operand, target,    | instruction
//           | next_pc                                      |
//  out      | out_valid, out_stall, acc_out .. mem_data    | registers, PC
//  cfg      | cfg_we, cfg_data                             | BRK vector
//
// Instructions without stack traffic are accepted back to back while the output
// is not stalled. Stack instructions move through PUSH or PULL, one stack byte
// per step, and then DONE, since the stack RAM has a single port with a registered
// read (PHA, PHP, PLA and PLP move one byte, JSR and RTS two, BRK and RTI three).
// Reset sets A=X=Y=0, S=FD, P=24; stack contents are undefined until written.
// A stalled result holds in the output register while the next request waits.
module cpu6502_execute_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  cmd,
    input  logic [7:0]  operand,
    input  logic [15:0] target,
    input  logic [15:0] next_pc,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  acc_out,
    output logic [7:0]  x_out,
    output logic [7:0]  y_out,
    output logic [7:0]  status_out,
    output logic [7:0]  sp_out,
    output logic [15:0] new_pc,
    output logic        mem_write,
    output logic [7:0]  mem_data
);
    import c65x_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_PULL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [7:0]  a_reg, x_reg, y_reg, s_reg, p_reg;
    logic [15:0] vec_reg;
    logic [1:0]  state_reg;
    logic [1:0]  cnt_reg;
    logic        rd_pend_reg;
    logic [7:0]  op_reg;
    logic [15:0] npc_reg, tgt_reg;
    logic [7:0]  pull0_reg, pull1_reg;

    logic [7:0]  stack_mem [STACK_DEPTH];
    logic [7:0]  rd_data_reg;

    logic        in_acc, out_free;
    logic        out_load;
    logic        res_load;

    assign out_free = !out_valid || !out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;

    // Combinational execute of non-stack instructions.
    logic [7:0]  a_n, x_n, y_n, p_n, dat_n;
    logic [15:0] pc_n;
    logic        wr_n;
    logic [8:0]  sum;
    logic [7:0]  mop, r8;
    logic        take;

    always_comb
    begin
        a_n = a_reg; x_n = x_reg; y_n = y_reg; p_n = p_reg;
        pc_n = next_pc; wr_n = 1'b0; dat_n = 8'h00; take = 1'b0;
        mop = ((cmd & 8'hE3) == 8'hE1) ? ~operand : operand;
        sum = {1'b0, a_reg} + {1'b0, mop} + {8'h00, p_reg[FC]};
        r8 = 8'h00;
        case (cmd)
            8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71,
            8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1:
            begin
                a_n = sum[7:0]; p_n[FC] = sum[8];
                p_n[FV] = ~(a_reg[7] ^ mop[7]) & (a_reg[7] ^ sum[7]);
                r8 = sum[7:0];
            end
            8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31:
            begin a_n = a_reg & operand; r8 = a_n; end
            8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11:
            begin a_n = a_reg | operand; r8 = a_n; end
            8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51:
            begin a_n = a_reg ^ operand; r8 = a_n; end
            8'h0A: begin p_n[FC] = a_reg[7]; a_n = {a_reg[6:0], 1'b0}; r8 = a_n; end
            8'h2A: begin p_n[FC] = a_reg[7]; a_n = {a_reg[6:0], p_reg[FC]}; r8 = a_n; end
            8'h4A: begin p_n[FC] = a_reg[0]; a_n = {1'b0, a_reg[7:1]}; r8 = a_n; end
            8'h6A: begin p_n[FC] = a_reg[0]; a_n = {p_reg[FC], a_reg[7:1]}; r8 = a_n; end
            8'h06, 8'h16, 8'h0E, 8'h1E:
            begin p_n[FC] = operand[7]; dat_n = {operand[6:0], 1'b0}; wr_n = 1'b1; r8 = dat_n; end
            8'h26, 8'h36, 8'h2E, 8'h3E:
            begin
                p_n[FC] = operand[7]; dat_n = {operand[6:0], p_reg[FC]};
                wr_n = 1'b1; r8 = dat_n;
            end
            8'h46, 8'h56, 8'h4E, 8'h5E:
            begin p_n[FC] = operand[0]; dat_n = {1'b0, operand[7:1]}; wr_n = 1'b1; r8 = dat_n; end
            8'h66, 8'h76, 8'h6E, 8'h7E:
            begin
                p_n[FC] = operand[0]; dat_n = {p_reg[FC], operand[7:1]};
                wr_n = 1'b1; r8 = dat_n;
            end
            8'hE6, 8'hF6, 8'hEE, 8'hFE:
            begin dat_n = operand + 8'd1; wr_n = 1'b1; r8 = dat_n; end
            8'hC6, 8'hD6, 8'hCE, 8'hDE:
            begin dat_n = operand - 8'd1; wr_n = 1'b1; r8 = dat_n; end
            8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1:
            begin p_n[FC] = a_reg >= operand; r8 = a_reg - operand; end
            8'hE0, 8'hE4, 8'hEC:
            begin p_n[FC] = x_reg >= operand; r8 = x_reg - operand; end
            8'hC0, 8'hC4, 8'hCC:
            begin p_n[FC] = y_reg >= operand; r8 = y_reg - operand; end
            8'hCA: begin x_n = x_reg - 8'd1; r8 = x_n; end
            8'h88: begin y_n = y_reg - 8'd1; r8 = y_n; end
            8'hE8: begin x_n = x_reg + 8'd1; r8 = x_n; end
            8'hC8: begin y_n = y_reg + 8'd1; r8 = y_n; end
            8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1:
            begin a_n = operand; r8 = a_n; end
            8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: begin x_n = operand; r8 = x_n; end
            8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: begin y_n = operand; r8 = y_n; end
            8'hAA: begin x_n = a_reg; r8 = x_n; end
            8'hA8: begin y_n = a_reg; r8 = y_n; end
            8'hBA: begin x_n = s_reg; r8 = x_n; end
            8'h8A: begin a_n = x_reg; r8 = a_n; end
            8'h98: begin a_n = y_reg; r8 = a_n; end
            default: ;
        endcase
        // Every arm above that set r8 also updates N and Z from it.
        case (cmd)
            8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71,
            8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1,
            8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31,
            8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11,
            8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51,
            8'h0A, 8'h2A, 8'h4A, 8'h6A,
            8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
            8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E,
            8'hE6, 8'hF6, 8'hEE, 8'hFE, 8'hC6, 8'hD6, 8'hCE, 8'hDE,
            8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1,
            8'hE0, 8'hE4, 8'hEC, 8'hC0, 8'hC4, 8'hCC,
            8'hCA, 8'h88, 8'hE8, 8'hC8,
            8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1,
            8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE, 8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC,
            8'hAA, 8'hA8, 8'hBA, 8'h8A, 8'h98:
            begin p_n[FZ] = (r8 == 8'h00); p_n[FN] = r8[7]; end
            8'h24, 8'h2C:
            begin
                p_n[FZ] = ((a_reg & operand) == 8'h00);
                p_n[FV] = operand[6]; p_n[FN] = operand[7];
            end
            8'h90: take = !p_reg[FC];
            8'hB0: take = p_reg[FC];
            8'hD0: take = !p_reg[FZ];
            8'hF0: take = p_reg[FZ];
            8'h10: take = !p_reg[FN];
            8'h30: take = p_reg[FN];
            8'h50: take = !p_reg[FV];
            8'h70: take = p_reg[FV];
            8'h18: p_n[FC] = 1'b0;
            8'h38: p_n[FC] = 1'b1;
            8'hD8: p_n[FD] = 1'b0;
            8'hF8: p_n[FD] = 1'b1;
            8'h58: p_n[FI] = 1'b0;
            8'h78: p_n[FI] = 1'b1;
            8'hB8: p_n[FV] = 1'b0;
            8'h4C, 8'h6C: pc_n = target;
            8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91:
            begin dat_n = a_reg; wr_n = 1'b1; end
            8'h86, 8'h96, 8'h8E: begin dat_n = x_reg; wr_n = 1'b1; end
            8'h84, 8'h94, 8'h8C: begin dat_n = y_reg; wr_n = 1'b1; end
            default: ;
        endcase
        if (take)
        begin
            pc_n = next_pc + {{8{operand[7]}}, operand};
        end
    end

    logic is_push, is_pull, is_sxs;
    assign is_push = (push_count(cmd) != 2'd0);
    assign is_pull = (pull_count(cmd) != 2'd0);
    assign is_sxs  = (cmd == 8'h9A);

    // Stack RAM port.
    logic        st_we;
    logic [7:0]  st_wd;
    logic [7:0]  st_addr;
    logic [7:0]  push_byte;
    logic [15:0] jsr_ret;

    assign jsr_ret = npc_reg - 16'd1;

    always_comb
    begin
        push_byte = 8'h00;
        case (op_reg)
            OP_BRK:
                push_byte = (cnt_reg == 2'd3) ? npc_reg[15:8] :
                            (cnt_reg == 2'd2) ? npc_reg[7:0]  : (p_reg | 8'h30);
            OP_JSR:  push_byte = (cnt_reg == 2'd2) ? jsr_ret[15:8] : jsr_ret[7:0];
            OP_PHA:  push_byte = a_reg;
            OP_PHP:  push_byte = p_reg | 8'h30;
            default: push_byte = 8'h00;
        endcase
    end

    assign st_we   = (state_reg == ST_PUSH);
    assign st_wd   = push_byte;
    assign st_addr = (state_reg == ST_PUSH) ? s_reg : s_reg + 8'd1;

    // The read data is held once pulling ends, so a stalled result keeps it.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stack_mem[st_addr[SAW-1:0]] <= st_wd;
        end
        if (state_reg == ST_PULL)
        begin
            rd_data_reg <= stack_mem[st_addr[SAW-1:0]];
        end
    end

    // Output register.
    logic [7:0]  o_a_n, o_p_n;
    logic [15:0] o_pc_n;
    logic [15:0] pulled_w;

    assign pulled_w = {rd_data_reg, pull0_reg};

    always_comb
    begin
        o_a_n  = a_reg;
        o_p_n  = p_reg;
        o_pc_n = npc_reg;
        case (op_reg)
            OP_BRK:  begin o_p_n[FI] = 1'b1; o_pc_n = vec_reg; end
            OP_JSR:  o_pc_n = tgt_reg;
            OP_RTS:  o_pc_n = pulled_w + 16'd1;
            OP_RTI:  begin o_p_n = (pull1_reg & 8'hEF) | 8'h20; o_pc_n = pulled_w; end
            OP_PLA:
            begin
                o_a_n = rd_data_reg; o_p_n[FZ] = (rd_data_reg == 8'h00);
                o_p_n[FN] = rd_data_reg[7];
            end
            OP_PLP:  o_p_n = (rd_data_reg & 8'hEF) | 8'h20;
            default: ;
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && out_free;
    assign res_load = (in_acc && !is_push && !is_pull) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= 8'h00; x_reg <= 8'h00; y_reg <= 8'h00;
            s_reg <= SP_RESET; p_reg <= P_RESET; vec_reg <= 16'h0000;
            state_reg <= ST_IDLE; cnt_reg <= 2'd0; rd_pend_reg <= 1'b0;
            pull0_reg <= 8'h00; pull1_reg <= 8'h00;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vec_reg <= cfg_data;
            end
            out_valid <= res_load || (out_valid && out_stall);
            rd_pend_reg <= (state_reg == ST_PULL);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (is_push)
                        begin
                            state_reg <= ST_PUSH; cnt_reg <= push_count(cmd);
                        end
                        else if (is_pull)
                        begin
                            state_reg <= ST_PULL; cnt_reg <= pull_count(cmd);
                        end
                        else
                        begin
                            a_reg <= a_n; x_reg <= x_n; y_reg <= y_n; p_reg <= p_n;
                            if (is_sxs)
                            begin
                                s_reg <= x_reg;
                            end
                        end
                    end
                end
                ST_PUSH:
                begin
                    s_reg <= s_reg - 8'd1;
                    cnt_reg <= cnt_reg - 2'd1;
                    if (cnt_reg == 2'd1)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_PULL:
                begin
                    // Each read lands in the next cycle; capture the previous byte.
                    s_reg <= s_reg + 8'd1;
                    cnt_reg <= cnt_reg - 2'd1;
                    if (rd_pend_reg)
                    begin
                        pull1_reg <= pull0_reg;
                        pull0_reg <= rd_data_reg;
                    end
                    if (cnt_reg == 2'd1)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        a_reg <= o_a_n; p_reg <= o_p_n;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // For RTI, pull0 holds PC low and pull1 holds P when DONE is reached.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg <= cmd; npc_reg <= next_pc; tgt_reg <= target;
        end
        if (in_acc && !is_push && !is_pull)
        begin
            acc_out <= a_n; x_out <= x_n; y_out <= y_n; status_out <= p_n;
            sp_out <= is_sxs ? x_reg : s_reg;
            new_pc <= pc_n; mem_write <= wr_n; mem_data <= wr_n ? dat_n : 8'h00;
        end
        else if (out_load)
        begin
            acc_out <= o_a_n; x_out <= x_reg; y_out <= y_reg; status_out <= o_p_n;
            sp_out <= s_reg; new_pc <= o_pc_n; mem_write <= 1'b0; mem_data <= 8'h00;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("request accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");
    a_push_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |=> (s_reg == $past(s_reg) - 8'd1))
        else $error("stack pointer not decremented on push");
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_free) |=> (state_reg == ST_DONE))
        else $error("result lost while output stalled");

endmodule
